// ----- rtl/core/sorted_event_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// sorted event priority queue: assertion macros
// Shared check macros, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_EVENT_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every edge
`define SEPQ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("sepq check failed");
// condition followed in the next cycle by a consequence
`define SEPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sepq check failed");
`else
`define SEPQ_ASSERT(label, prop)
`define SEPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/sepq_pkg.sv -----
// ----------------------------------------------------------------------------
// sepq_pkg
// Types, codes and the ranking function shared by the queue cells and top.
// ----------------------------------------------------------------------------
package sepq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int PRIO_W        = 16;
   localparam int DUE_W         = 32;
   localparam int COUNT_W       = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                     valid;
      logic                     ins_take;
      logic signed [PRIO_W-1:0] prio;
      logic [DUE_W-1:0]         due;
   } link_type;

   // request broadcast to every cell
   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic signed [PRIO_W-1:0] prio;
      logic [DUE_W-1:0]         due;
   } cmd_type;

   // true when event a ranks strictly ahead of event b
   function automatic logic ranks_ahead(
      input logic signed [PRIO_W-1:0] a_prio,
      input logic [DUE_W-1:0]         a_due,
      input logic signed [PRIO_W-1:0] b_prio,
      input logic [DUE_W-1:0]         b_due
   );
      logic result;
      if (a_prio != b_prio) begin
         result = (a_prio > b_prio);
      end else begin
         result = (a_due < b_due);
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/sepq_cell.sv -----
// ----------------------------------------------------------------------------
// sepq_cell
// One slot of the sorted list: holds an event and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sepq_cell (
   input  logic              clock,
   input  logic              reset,
   input  sepq_pkg::cmd_type  cmd,
   input  sepq_pkg::link_type prev_link,
   input  sepq_pkg::link_type next_link,
   output sepq_pkg::link_type own_link,
   output logic              match
);
   import sepq_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [PRIO_W-1:0] prio_ff, prio_in;
   logic [DUE_W-1:0]         due_ff, due_in;
   logic                     ins_take;
   logic                     rem_shift;

   // new event goes here or further up; an empty slot always takes
   assign ins_take  = !valid_ff || ranks_ahead(cmd.prio, cmd.due, prio_ff, due_ff);
   // slot lies at or after the first matching entry
   assign rem_shift = valid_ff && !ranks_ahead(prio_ff, due_ff, cmd.prio, cmd.due);
   assign match     = valid_ff && (prio_ff == cmd.prio) && (due_ff == cmd.due);

   assign own_link.valid    = valid_ff;
   assign own_link.ins_take = ins_take;
   assign own_link.prio     = prio_ff;
   assign own_link.due      = due_ff;

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      due_in   = due_ff;
      if (cmd.insert && ins_take) begin
         if (prev_link.ins_take) begin
            // make room: take the neighbor's entry
            valid_in = prev_link.valid;
            prio_in  = prev_link.prio;
            due_in   = prev_link.due;
         end else begin
            valid_in = 1'b1;
            prio_in  = cmd.prio;
            due_in   = cmd.due;
         end
      end else if (cmd.remove && rem_shift) begin
         valid_in = next_link.valid;
         prio_in  = next_link.prio;
         due_in   = next_link.due;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff <= prio_in;
      due_ff  <= due_in;
   end

endmodule

// ----- rtl/core/sorted_event_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_event_priority_queue
// Bounded event list kept sorted by priority, then due time, in a cell chain.
// ----------------------------------------------------------------------------
// A request is accepted and its result is shown the next cycle;
// a new request is taken in the same cycle as the waiting result is taken, so
// the queue sustains one request per cycle when the result side is ready.
// Every cell compares the request against its own entry in parallel and the
// whole chain shifts by one slot in that same cycle; the cell compare
// (a 16-bit and a 32-bit magnitude compare) sets the cycle time, and the
// match OR across the chain grows with DEPTH. Head fields read zero when
// the list is empty. No clearing pass is needed after reset.
`include "sorted_event_priority_queue_defines.svh"

module sorted_event_priority_queue #(
   parameter int DEPTH = sepq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // priority_req [15:0], due_time [47:16]
   input  logic [0:0]  req_tuser,   // operation [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // entry_count [4:0], head_valid [5],
                                    // head_priority [21:6], head_due [53:22]
   output logic [1:0]  rsp_tuser    // status [1:0]
);
   import sepq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   link_type       links      [DEPTH];
   link_type       prev_links [DEPTH];
   link_type       next_links [DEPTH];
   logic [DEPTH-1:0] match_vec;
   logic [DEPTH-1:0] valid_vec;
   logic [DEPTH-1:0] valid_inc;
   cmd_type        cmd;
   op_type         op;
   logic           accept;
   logic           full;
   logic           found;
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     status_ff, status_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           head_valid;
   logic [PRIO_W-1:0] head_prio;
   logic [DUE_W-1:0]  head_due;

   assign op         = op_type'(req_tuser[0]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = links[DEPTH-1].valid;
   assign found      = |match_vec;

   assign cmd.prio   = req_tdata[15:0];
   assign cmd.due    = req_tdata[47:16];
   assign cmd.insert = accept && (op == OP_INSERT) && !full;
   assign cmd.remove = accept && (op == OP_REMOVE) && found;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid_vec[i] = links[i].valid;
         if (i == 0) begin
            prev_links[i] = '0;
         end else begin
            prev_links[i] = links[i-1];
         end
         if (i == DEPTH - 1) begin
            next_links[i] = '0;
         end else begin
            next_links[i] = links[i+1];
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      sepq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_link (prev_links[g]),
         .next_link (next_links[g]),
         .own_link  (links[g]),
         .match     (match_vec[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      cnt_in       = cnt_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (op)
            OP_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  status_in = STATUS_DONE;
                  cnt_in    = CNT_W'(cnt_ff + 1'b1);
               end
            end
            OP_REMOVE: begin
               if (found) begin
                  status_in = STATUS_DONE;
                  cnt_in    = CNT_W'(cnt_ff - 1'b1);
               end else begin
                  status_in = STATUS_NO_MATCH;
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_DONE;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         cnt_ff       <= cnt_in;
      end
   end

   // the chain only moves on an accepted request, so the head is the result
   assign head_valid = links[0].valid;
   assign head_prio  = head_valid ? links[0].prio : '0;
   assign head_due   = head_valid ? links[0].due  : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, head_due, head_prio, head_valid, COUNT_W'(cnt_ff)};

   assign valid_inc = valid_vec + {{(DEPTH-1){1'b0}}, 1'b1};

   `SEPQ_ASSERT(a_count_tracks_cells, cnt_ff == CNT_W'($countones(valid_vec)))
   `SEPQ_ASSERT(a_valid_prefix, (valid_inc & valid_vec) == '0)
   `SEPQ_ASSERT_NEXT(a_full_reported, accept && (op == OP_INSERT) && full, status_ff == STATUS_FULL)
   `SEPQ_ASSERT_NEXT(a_miss_holds_count, accept && (op == OP_REMOVE) && !found, $stable(cnt_ff))

endmodule

// ----- test/sepq_result_checker.sv -----
// ----------------------------------------------------------------------------
// sepq_result_checker
// Watches the request and result channels of the sorted event queue, keeps
// its own sorted copy of the held events and compares every result field.
// ----------------------------------------------------------------------------
module sepq_result_checker #(
   parameter int DEPTH = sepq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // priority_req [15:0], due_time [47:16]
   input  logic [0:0]  req_tuser,   // operation [0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // entry_count [4:0], head_valid [5],
                                    // head_priority [21:6], head_due [53:22]
   input  logic [1:0]  rsp_tuser,   // status [1:0]
   output int unsigned failures,
   output int unsigned pending,
   output int unsigned requests_seen,
   output int unsigned full_seen,
   output int unsigned no_match_seen,
   output int unsigned peak_held
);
   import sepq_pkg::*;

   typedef struct packed {
      status_type               status;
      logic [COUNT_W-1:0]       count;
      logic                     head_valid;
      logic signed [PRIO_W-1:0] head_prio;
      logic [DUE_W-1:0]         head_due;
   } queue_result_type;

   logic signed [PRIO_W-1:0] held_prio [DEPTH];
   logic [DUE_W-1:0]         held_due  [DEPTH];
   int                       held_n;
   queue_result_type         expected_results [$];

   // true when the new event belongs in front of held entry idx
   function automatic logic goes_ahead(input logic signed [PRIO_W-1:0] p,
                                       input logic [DUE_W-1:0] d, input int idx);
      logic ahead;
      if (p != held_prio[idx]) begin
         ahead = (p > held_prio[idx]);
      end else begin
         ahead = (d < held_due[idx]);
      end
      return ahead;
   endfunction

   task automatic predict_request(input op_type op, input logic signed [PRIO_W-1:0] p,
                                  input logic [DUE_W-1:0] d);
      queue_result_type r;
      int pos;
      r.status = STATUS_DONE;
      pos = 0;
      if (op == OP_INSERT) begin
         if (held_n >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // equal events fall through, so the new one lands after them
            while (pos < held_n && !goes_ahead(p, d, pos)) pos++;
            for (int k = held_n; k > pos; k--) begin
               held_prio[k] = held_prio[k-1];
               held_due[k]  = held_due[k-1];
            end
            held_prio[pos] = p;
            held_due[pos]  = d;
            held_n++;
         end
      end else begin
         while (pos < held_n && !(held_prio[pos] == p && held_due[pos] == d)) pos++;
         if (pos >= held_n) begin
            r.status = STATUS_NO_MATCH;
         end else begin
            for (int k = pos; k + 1 < held_n; k++) begin
               held_prio[k] = held_prio[k+1];
               held_due[k]  = held_due[k+1];
            end
            held_n--;
         end
      end
      r.count      = COUNT_W'(held_n);
      r.head_valid = (held_n > 0);
      r.head_prio  = (held_n > 0) ? held_prio[0] : '0;
      r.head_due   = (held_n > 0) ? held_due[0] : '0;
      expected_results.push_back(r);
      requests_seen++;
      if (r.status == STATUS_FULL) full_seen++;
      if (r.status == STATUS_NO_MATCH) no_match_seen++;
      if (held_n > peak_held) peak_held = held_n;
   endtask

   always @(posedge clock) begin : watch
      queue_result_type got;
      queue_result_type want;
      if (reset) begin
         held_n = 0;
         expected_results.delete();
         failures      = 0;
         requests_seen = 0;
         full_seen     = 0;
         no_match_seen = 0;
         peak_held     = 0;
      end else begin
         // a result always belongs to an earlier request, so check it first
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tuser);
            got.count      = rsp_tdata[4:0];
            got.head_valid = rsp_tdata[5];
            got.head_prio  = rsp_tdata[21:6];
            got.head_due   = rsp_tdata[53:22];
            if (expected_results.size() == 0) begin
               if (failures < 10) begin
                  $display("unexpected result: status %0d count %0d valid %0b",
                           got.status, got.count, got.head_valid);
               end
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (failures < 10) begin
                     $display({"mismatch expected: status %0d count %0d valid %0b",
                               " prio %0d due %0h"},
                              want.status, want.count, want.head_valid, want.head_prio,
                              want.head_due);
                     $display({"         actual:   status %0d count %0d valid %0b",
                               " prio %0d due %0h"},
                              got.status, got.count, got.head_valid, got.head_prio,
                              got.head_due);
                  end
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_request(op_type'(req_tuser[0]), req_tdata[15:0], req_tdata[47:16]);
         end
      end
      pending = expected_results.size();
   end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives insert and remove requests into the sorted event queue: a directed
// pass over extremes, duplicates, full and empty cases, then random traffic
// with idling on both sides. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
   import sepq_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1525;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // priority_req [15:0], due_time [47:16]
   logic [0:0]  req_tuser;   // operation [0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // entry_count [4:0], head_valid [5],
                             // head_priority [21:6], head_due [53:22]
   logic [1:0]  rsp_tuser;   // status [1:0]

   int unsigned failures;
   int unsigned pending;
   int unsigned requests_seen;
   int unsigned full_seen;
   int unsigned no_match_seen;
   int unsigned peak_held;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   // events the queue should be holding, in no particular order
   logic signed [PRIO_W-1:0] live_prio [$];
   logic [DUE_W-1:0]         live_due  [$];

   sorted_event_priority_queue #(.DEPTH(DEPTH_DEFAULT)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sepq_result_checker #(.DEPTH(DEPTH_DEFAULT)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .failures      (failures),
      .pending       (pending),
      .requests_seen (requests_seen),
      .full_seen     (full_seen),
      .no_match_seen (no_match_seen),
      .peak_held     (peak_held)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD/2) clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no request or result moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_request(input op_type op, input logic signed [PRIO_W-1:0] p,
                               input logic [DUE_W-1:0] d);
      int idx;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d, p};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_INSERT) begin
         if (live_prio.size() < DEPTH_DEFAULT) begin
            live_prio.push_back(p);
            live_due.push_back(d);
         end
      end else begin
         for (idx = 0; idx < live_prio.size(); idx++) begin
            if (live_prio[idx] == p && live_due[idx] == d) break;
         end
         if (idx < live_prio.size()) begin
            live_prio.delete(idx);
            live_due.delete(idx);
         end
      end
   endtask

   // mix of crowded values for ties, field extremes and full-range values
   function automatic void random_event(output logic signed [PRIO_W-1:0] p,
                                        output logic [DUE_W-1:0] d);
      case ($urandom_range(3))
         0: begin
            p = PRIO_W'($urandom_range(4)) - 16'sd2;
            d = $urandom_range(3);
         end
         1: begin
            case ($urandom_range(3))
               0: p = 16'sh8000;
               1: p = 16'sh7fff;
               2: p = 16'sh0000;
               default: p = 16'shffff;
            endcase
            case ($urandom_range(3))
               0: d = 32'h0000_0000;
               1: d = 32'hffff_ffff;
               2: d = 32'h0000_0001;
               default: d = 32'h7fff_ffff;
            endcase
         end
         default: begin
            p = PRIO_W'($urandom);
            d = $urandom;
         end
      endcase
   endfunction

   initial begin : stimulus
      logic signed [PRIO_W-1:0] p;
      logic [DUE_W-1:0]         d;
      int                       idx;
      int                       n;
      int unsigned              ins_pct;
      int unsigned              pick;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_INSERT;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      ins_pct       = 50;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 55;

      // remove from an empty list
      send_request(OP_REMOVE, 16'sd0, 32'd0);
      send_request(OP_INSERT, 16'sh7fff, 32'hffff_ffff);
      send_request(OP_INSERT, 16'sh8000, 32'h0000_0000);
      send_request(OP_INSERT, 16'sd0, 32'd100);
      // duplicate goes behind its twin
      send_request(OP_INSERT, 16'sd0, 32'd100);
      send_request(OP_INSERT, 16'sd0, 32'd50);
      send_request(OP_INSERT, 16'sd0, 32'd200);
      send_request(OP_INSERT, 16'sh7fff, 32'h0000_0000);
      send_request(OP_INSERT, 16'sh8000, 32'hffff_ffff);
      send_request(OP_INSERT, -16'sd1, 32'd1);
      send_request(OP_INSERT, 16'sd1, 32'h8000_0000);
      send_request(OP_REMOVE, 16'sd0, 32'd100);
      send_request(OP_REMOVE, 16'sd5, 32'd5);
      send_request(OP_REMOVE, 16'sh7fff, 32'h0000_0000);
      // fill to capacity, then overflow and miss on a full list
      for (idx = 0; idx < 8; idx++) begin
         send_request(OP_INSERT, PRIO_W'(idx * 1000 - 3000), DUE_W'(idx));
      end
      send_request(OP_INSERT, 16'sd7, 32'd7);
      send_request(OP_REMOVE, 16'sd123, 32'd456);
      send_request(OP_REMOVE, 16'sh8000, 32'hffff_ffff);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 10;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // swing between draining and filling so empty and full both recur
         if (n % 64 == 0) begin
            case ($urandom_range(2))
               0: ins_pct = 30;
               1: ins_pct = 55;
               default: ins_pct = 80;
            endcase
         end
         if ($urandom_range(99) < ins_pct) begin
            random_event(p, d);
            send_request(OP_INSERT, p, d);
         end else begin
            pick = $urandom_range(99);
            if (live_prio.size() > 0 && pick < 70) begin
               idx = $urandom_range(live_prio.size() - 1);
               p   = live_prio[idx];
               d   = live_due[idx];
            end else if (live_prio.size() > 0 && pick < 85) begin
               // near miss on the due time
               idx = $urandom_range(live_prio.size() - 1);
               p   = live_prio[idx];
               d   = live_due[idx] ^ 32'h1;
            end else begin
               random_event(p, d);
            end
            send_request(OP_REMOVE, p, d);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d inserts refused as full, %0d removes with no match",
               requests_seen, full_seen, no_match_seen);
      $display("queue held up to %0d events, %0d mismatches", peak_held, failures);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
